// ===== hw/rtl/mexp_pkg.sv =====
// mexp_pkg: shared types and constants of the modular exponentiation unit
// no dependencies; used by mexp_mulmod and modular_exponentiation_unit

package mexp_pkg;

   localparam int MOD_W        = 31;
   localparam int BASE_W       = 32;
   localparam int MUL_BITS     = 32;
   localparam int MUL_CNT_W    = $clog2(MUL_BITS + 1);
   localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;
   localparam logic [MOD_W-1:0] MODULUS_MIN   = 31'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

endpackage

// ===== hw/rtl/mexp_mulmod.sv =====
// mexp_mulmod: bit-serial modular multiplier, one multiplier bit per cycle, msb first
// depends on mexp_pkg; operands below the modulus except op_a, which may be any 32-bit value

module mexp_mulmod (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [mexp_pkg::BASE_W-1:0]     op_a,
   input  logic [mexp_pkg::MOD_W-1:0]      op_b,
   input  logic [mexp_pkg::MOD_W-1:0]      modulus,
   output mexp_pkg::mul_status_type        status,
   output logic [mexp_pkg::MOD_W-1:0]      product
);

   logic [mexp_pkg::BASE_W-1:0]    a_ff;
   logic [mexp_pkg::MOD_W-1:0]     b_ff;
   logic [mexp_pkg::MOD_W-1:0]     r_ff;
   logic [mexp_pkg::MOD_W-1:0]     r_in;
   logic [mexp_pkg::MUL_CNT_W-1:0] cnt_ff;
   logic                           done_ff;

   logic [mexp_pkg::MOD_W:0]       m_ext;
   logic [mexp_pkg::MOD_W:0]       dbl;
   logic [mexp_pkg::MOD_W:0]       dbl_red;
   logic [mexp_pkg::MOD_W:0]       sum;
   logic [mexp_pkg::MOD_W:0]       sum_red;

   // r = (2r + bit * b) mod m, two conditional subtracts
   always_comb begin
      m_ext   = {1'b0, modulus};
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
      sum     = dbl_red + (a_ff[mexp_pkg::BASE_W-1] ? {1'b0, b_ff} : '0);
      sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
      r_in    = sum_red[mexp_pkg::MOD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            a_ff   <= op_a;
            b_ff   <= op_b;
            r_ff   <= '0;
            cnt_ff <= mexp_pkg::MUL_CNT_W'(mexp_pkg::MUL_BITS);
         end else if (cnt_ff != '0) begin
            r_ff    <= r_in;
            a_ff    <= {a_ff[mexp_pkg::BASE_W-2:0], 1'b0};
            cnt_ff  <= cnt_ff - mexp_pkg::MUL_CNT_W'(1);
            done_ff <= (cnt_ff == mexp_pkg::MUL_CNT_W'(1));
         end
      end
   end

   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;
   assign product     = r_ff;

   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      start |=> status.busy)
      else $error("multiplier did not go busy after start");

   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      status.done |-> !status.busy)
      else $error("multiplier done while still busy");

   a_done_after_last : assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == mexp_pkg::MUL_CNT_W'(1)) && !start |=> status.done)
      else $error("multiplier missed its done pulse");

endmodule

// ===== hw/rtl/modular_exponentiation_unit.sv =====
// modular_exponentiation_unit: base^exponent mod modulus by right-to-left square-and-multiply
// depends on mexp_pkg and mexp_mulmod (one shared bit-serial modular multiplier)
//
// channel   ports                                 handshake
// request   req_base_value, req_exponent          start & !busy
// response  rsp_residue                           rsp_valid, one cycle
// config    csr_wdata                             csr_we
//
// the base is reduced first (one multiplier pass), then each of EXP_BITS exponent bits
// takes one squaring and, for a set bit, one multiply
// a modulus below two answers 0 in the cycle after the item is taken
// reset is synchronous and restores the modulus to 1000000007
// busy is high while an item is at work; results cannot be stalled

module modular_exponentiation_unit #(
   parameter int EXP_BITS = 63
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [mexp_pkg::BASE_W-1:0]      req_base_value,
   input  logic [EXP_BITS-1:0]              req_exponent,
   output logic                             rsp_valid,
   output logic [mexp_pkg::MOD_W-1:0]       rsp_residue,
   input  logic                             csr_we,
   input  logic [mexp_pkg::MOD_W-1:0]       csr_wdata
);

   localparam int BIT_CNT_W = $clog2(EXP_BITS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_BIT,
      ST_MUL,
      ST_SQR
   } state_type;

   state_type                    state_ff;
   logic [mexp_pkg::MOD_W-1:0]   modulus_ff;
   logic [EXP_BITS-1:0]          exp_ff;
   logic [BIT_CNT_W-1:0]         bit_cnt_ff;
   logic [mexp_pkg::MOD_W-1:0]   acc_ff;
   logic [mexp_pkg::MOD_W-1:0]   base_ff;
   logic                         mul_start_ff;
   logic [mexp_pkg::BASE_W-1:0]  op_a_ff;
   logic [mexp_pkg::MOD_W-1:0]   op_b_ff;
   logic                         rsp_valid_ff;
   logic [mexp_pkg::MOD_W-1:0]   rsp_residue_ff;

   mexp_pkg::mul_status_type     mul_sts;
   logic [mexp_pkg::MOD_W-1:0]   mul_product;
   logic                         accept;

   assign accept = start && (state_ff == ST_IDLE);

   mexp_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .op_a    (op_a_ff),
      .op_b    (op_b_ff),
      .modulus (modulus_ff),
      .status  (mul_sts),
      .product (mul_product)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         modulus_ff   <= mexp_pkg::MODULUS_RESET;
         mul_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            modulus_ff <= csr_wdata;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (modulus_ff < mexp_pkg::MODULUS_MIN) begin
                     rsp_valid_ff   <= 1'b1;
                     rsp_residue_ff <= '0;
                  end else begin
                     exp_ff       <= req_exponent;
                     bit_cnt_ff   <= BIT_CNT_W'(EXP_BITS);
                     acc_ff       <= mexp_pkg::MOD_W'(1);
                     op_a_ff      <= req_base_value;
                     op_b_ff      <= mexp_pkg::MOD_W'(1);
                     mul_start_ff <= 1'b1;
                     state_ff     <= ST_REDUCE;
                  end
               end
            end
            ST_REDUCE: begin
               if (mul_sts.done) begin
                  base_ff  <= mul_product;
                  state_ff <= ST_BIT;
               end
            end
            ST_BIT: begin
               if (bit_cnt_ff == '0) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_residue_ff <= acc_ff;
                  state_ff       <= ST_IDLE;
               end else if (exp_ff[0]) begin
                  op_a_ff      <= {1'b0, acc_ff};
                  op_b_ff      <= base_ff;
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_MUL;
               end else begin
                  op_a_ff      <= {1'b0, base_ff};
                  op_b_ff      <= base_ff;
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_SQR;
               end
            end
            ST_MUL: begin
               if (mul_sts.done) begin
                  acc_ff       <= mul_product;
                  op_a_ff      <= {1'b0, base_ff};
                  op_b_ff      <= base_ff;
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_SQR;
               end
            end
            ST_SQR: begin
               if (mul_sts.done) begin
                  base_ff    <= mul_product;
                  exp_ff     <= exp_ff >> 1;
                  bit_cnt_ff <= bit_cnt_ff - BIT_CNT_W'(1);
                  state_ff   <= ST_BIT;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_residue = rsp_residue_ff;

   a_done_in_wait : assert property (@(posedge clock) disable iff (reset)
      mul_sts.done |-> (state_ff == ST_REDUCE) || (state_ff == ST_MUL) || (state_ff == ST_SQR))
      else $error("multiplier result arrived with no pass outstanding");

   a_residue_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (modulus_ff >= mexp_pkg::MODULUS_MIN) |-> rsp_residue < modulus_ff)
      else $error("residue not below modulus");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy && (modulus_ff >= mexp_pkg::MODULUS_MIN) |=> busy && !rsp_valid)
      else $error("item taken but unit not busy");

   a_one_pass : assert property (@(posedge clock) disable iff (reset)
      mul_start_ff |-> !mul_sts.busy)
      else $error("multiplier restarted while busy");

endmodule
